FILE: rtl/mkrt_pkg.sv
// ----------------------------------------------------------------------------
// mkrt_pkg
// shared sizes, codes, control/status bundles and text normalization for the
// multi-key record table
// ----------------------------------------------------------------------------
`default_nettype none

package mkrt_pkg;

  // table geometry
  localparam int ENTRIES    = 64;
  localparam int TEXT_BYTES = 12;
  localparam int FIELDS     = 4;

  // text carried as two halves, first character in the top byte
  localparam int HALF_W     = 48;
  localparam int TEXT_W     = 2 * HALF_W;
  localparam int TEXT_CHARS = TEXT_W / 8;

  localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int COUNT_W    = $clog2(ENTRIES + 1);
  localparam int SLOT_W     = 6;
  localparam int ECOUNT_W   = 7;
  localparam int SEL_W      = 2;

  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [TEXT_W-1:0]  text_t;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_SEARCH = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    RES_INSERTED  = 3'd0,
    RES_FULL      = 3'd1,
    RES_FOUND     = 3'd2,
    RES_NOT_FOUND = 3'd3,
    RES_DELETED   = 3'd4
  } res_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_SCAN,
    S_SRCH_SCAN,
    S_SRCH_DRAIN,
    S_SRCH_READ,
    S_FINISH
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic capture;    // take the input beat, clear scan index and hit
    logic scan_rd;    // memory read at scan index feeds the compare next cycle
    logic idx_inc;
    logic addr_scan;  // memory address from scan index, else from hit index
    logic ins_write;  // write record at scan index, mark valid
    logic del_clear;  // clear valid mark of hit entry
    logic load_out;   // load the result register
    res_t res;
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    cmd_t new_cmd;
    logic idx_free;
    logic idx_last;
    logic hit_found;
    logic out_free;
  } dp_stat_t;

  // zero after the first nul byte, and limit to TEXT_BYTES-1 characters
  function automatic text_t normalize(input text_t t);
    text_t r;
    logic  ended;
    r     = t;
    ended = 1'b0;
    for (int k = 0; k < TEXT_CHARS; k++) begin
      if (t[TEXT_W-1-8*k -: 8] == 8'h00 || k >= TEXT_BYTES - 1) begin
        ended = 1'b1;
      end
      if (ended) begin
        r[TEXT_W-1-8*k -: 8] = 8'h00;
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/mkrt_ram.sv
// ----------------------------------------------------------------------------
// mkrt_ram
// single-port synchronous ram, one write or read per cycle, registered read
// ----------------------------------------------------------------------------
`default_nettype none

module mkrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  wire logic [WIDTH-1:0]                      wdata,
  output logic      [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

FILE: rtl/mkrt_datapath.sv
// ----------------------------------------------------------------------------
// mkrt_datapath
// record memories, valid marks, entry count, scan index, key compare and the
// result register
// ----------------------------------------------------------------------------
`default_nettype none

module mkrt_datapath
  import mkrt_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire ctl_cmd_t             cmd,
  output dp_stat_t                  stat,
  // input beat
  input  wire logic [1:0]           command,
  input  wire logic [SEL_W-1:0]     key_field,
  input  wire logic [HALF_W-1:0]    key_high,
  input  wire logic [HALF_W-1:0]    key_low,
  input  wire logic [HALF_W-1:0]    name_high,
  input  wire logic [HALF_W-1:0]    name_low,
  input  wire logic [HALF_W-1:0]    id_high,
  input  wire logic [HALF_W-1:0]    id_low,
  input  wire logic [HALF_W-1:0]    phone_high,
  input  wire logic [HALF_W-1:0]    phone_low,
  input  wire logic [HALF_W-1:0]    msgr_high,
  input  wire logic [HALF_W-1:0]    msgr_low,
  // result beat
  input  wire logic                 out_stall,
  output logic                      out_valid,
  output logic [2:0]                status,
  output logic [SLOT_W-1:0]         slot,
  output logic [ECOUNT_W-1:0]       entry_count,
  output logic [HALF_W-1:0]         out_name_high,
  output logic [HALF_W-1:0]         out_name_low,
  output logic [HALF_W-1:0]         out_id_high,
  output logic [HALF_W-1:0]         out_id_low,
  output logic [HALF_W-1:0]         out_phone_high,
  output logic [HALF_W-1:0]         out_phone_low,
  output logic [HALF_W-1:0]         out_msgr_high,
  output logic [HALF_W-1:0]         out_msgr_low
);

  logic [SEL_W-1:0]   key_sel;
  text_t              key_text;
  text_t              rec   [FIELDS];
  text_t              rdata [FIELDS];
  logic [ENTRIES-1:0] valid;
  count_t             count;
  idx_t               idx;
  idx_t               rd_idx;
  logic               rd_live;
  logic               hit_found;
  idx_t               hit_idx;
  idx_t               ram_addr;
  logic               match;
  logic               has_slot;
  logic               has_fields;

  assign ram_addr = cmd.addr_scan ? idx : hit_idx;
  assign match    = rd_live && valid[rd_idx] && (rdata[key_sel] == key_text);

  for (genvar f = 0; f < FIELDS; f++) begin : g_store
    mkrt_ram #(
      .WIDTH (TEXT_W),
      .DEPTH (ENTRIES)
    ) u_ram (
      .clk   (clk),
      .we    (cmd.ins_write),
      .addr  (ram_addr),
      .wdata (rec[f]),
      .rdata (rdata[f])
    );
  end

  assign stat.new_cmd   = cmd_t'(command);
  assign stat.idx_free  = !valid[idx];
  assign stat.idx_last  = (idx == idx_t'(ENTRIES - 1));
  assign stat.hit_found = hit_found;
  assign stat.out_free  = !out_valid || !out_stall;

  // captured beat, normalized on the way in
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      key_sel  <= key_field;
      key_text <= normalize({key_high, key_low});
      rec[0]   <= normalize({name_high, name_low});
      rec[1]   <= normalize({id_high, id_low});
      rec[2]   <= normalize({phone_high, phone_low});
      rec[3]   <= normalize({msgr_high, msgr_low});
    end
    if (cmd.scan_rd) begin
      rd_idx <= idx;
    end
  end

  // scan index, compare pipe, hit tracking, valid marks and count
  always_ff @(posedge clk) begin
    if (rst) begin
      valid     <= '0;
      count     <= '0;
      idx       <= '0;
      rd_live   <= 1'b0;
      hit_found <= 1'b0;
      hit_idx   <= '0;
    end else begin
      rd_live <= cmd.scan_rd;
      if (cmd.capture) begin
        idx       <= '0;
        hit_found <= 1'b0;
      end else if (cmd.idx_inc) begin
        idx <= idx + idx_t'(1);
      end
      // later matches overwrite, so the highest index wins
      if (match) begin
        hit_found <= 1'b1;
        hit_idx   <= rd_idx;
      end
      if (cmd.ins_write) begin
        valid[idx] <= 1'b1;
        count      <= count + count_t'(1);
        hit_idx    <= idx;
      end
      if (cmd.del_clear) begin
        valid[hit_idx] <= 1'b0;
        count          <= count - count_t'(1);
      end
    end
  end

  // result register
  always_comb begin
    has_slot   = (cmd.res == RES_INSERTED) || (cmd.res == RES_FOUND) ||
                 (cmd.res == RES_DELETED);
    has_fields = (cmd.res == RES_FOUND) || (cmd.res == RES_DELETED);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      status         <= cmd.res;
      slot           <= has_slot ? SLOT_W'(hit_idx) : '0;
      entry_count    <= ECOUNT_W'(count);
      out_name_high  <= has_fields ? rdata[0][TEXT_W-1:HALF_W] : '0;
      out_name_low   <= has_fields ? rdata[0][HALF_W-1:0]      : '0;
      out_id_high    <= has_fields ? rdata[1][TEXT_W-1:HALF_W] : '0;
      out_id_low     <= has_fields ? rdata[1][HALF_W-1:0]      : '0;
      out_phone_high <= has_fields ? rdata[2][TEXT_W-1:HALF_W] : '0;
      out_phone_low  <= has_fields ? rdata[2][HALF_W-1:0]      : '0;
      out_msgr_high  <= has_fields ? rdata[3][TEXT_W-1:HALF_W] : '0;
      out_msgr_low   <= has_fields ? rdata[3][HALF_W-1:0]      : '0;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/mkrt_ctrl.sv
// ----------------------------------------------------------------------------
// mkrt_ctrl
// sequencer for insert, search and delete: free-slot scan, key scan over all
// entries, hit readout and result handoff
// ----------------------------------------------------------------------------
`default_nettype none

module mkrt_ctrl
  import mkrt_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire dp_stat_t stat,
  output ctl_cmd_t      cmd
);

  state_t state, state_next;
  res_t   res, res_next;
  cmd_t   op, op_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      res   <= RES_NOT_FOUND;
      op    <= CMD_NONE;
    end else begin
      state <= state_next;
      res   <= res_next;
      op    <= op_next;
    end
  end

  always_comb begin
    state_next = state;
    res_next   = res;
    op_next    = op;
    cmd        = '0;
    cmd.res    = res;
    in_stall   = 1'b1;
    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          op_next     = stat.new_cmd;
          unique case (stat.new_cmd)
            CMD_INSERT: state_next = S_INS_SCAN;
            CMD_SEARCH,
            CMD_DELETE: state_next = S_SRCH_SCAN;
            CMD_NONE: begin
              res_next   = RES_NOT_FOUND;
              state_next = S_FINISH;
            end
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_INS_SCAN: begin
        cmd.addr_scan = 1'b1;
        if (stat.idx_free) begin
          cmd.ins_write = 1'b1;
          res_next      = RES_INSERTED;
          state_next    = S_FINISH;
        end else if (stat.idx_last) begin
          res_next   = RES_FULL;
          state_next = S_FINISH;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_SRCH_SCAN: begin
        cmd.addr_scan = 1'b1;
        cmd.scan_rd   = 1'b1;
        cmd.idx_inc   = 1'b1;
        if (stat.idx_last) begin
          state_next = S_SRCH_DRAIN;
        end
      end
      S_SRCH_DRAIN: begin
        // last entry compares this cycle
        state_next = S_SRCH_READ;
      end
      S_SRCH_READ: begin
        if (stat.hit_found) begin
          if (op == CMD_DELETE) begin
            cmd.del_clear = 1'b1;
            res_next      = RES_DELETED;
          end else begin
            res_next = RES_FOUND;
          end
        end else begin
          res_next = RES_NOT_FOUND;
        end
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/multi_key_record_table.sv
// ----------------------------------------------------------------------------
// multi_key_record_table
// table of ENTRIES records with four 12-byte text fields, insert into the
// lowest free slot, search or delete by any one field
// ----------------------------------------------------------------------------
// usage
//   input channel: in_valid / in_stall, one beat carries a command, a key
//   field select, the key and a full record. a beat is taken only while the
//   block is idle; in_stall stays high while a command is being worked on.
//   output channel: out_valid / out_stall, one result beat per input beat,
//   held in an output register so a stalled result does not hold up the
//   next input beat.
//   steps, input beat to result ready:
//     insert          scan of the valid marks that stops at the first free
//                     slot, or runs to the last entry when the table is full
//     search, delete  one entry read per cycle over all entries from the
//                     single-port field memories, then one compare drain,
//                     one hit readout and the handoff
//     unknown command no scan, straight to the handoff
//   commands: one at a time, the next input beat is taken once the result is loaded.
//   reset clears valid marks, entry count, sequencer and output valid; the
//   field memories are left as they are and their words only count for valid entries.
//   a stalled receiver holds the result; the block then takes one more input
//   beat and waits with its result until the output register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_key_record_table
  import mkrt_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  // input channel
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [1:0]           command,
  input  wire logic [SEL_W-1:0]     key_field,
  input  wire logic [HALF_W-1:0]    key_high,
  input  wire logic [HALF_W-1:0]    key_low,
  input  wire logic [HALF_W-1:0]    name_high,
  input  wire logic [HALF_W-1:0]    name_low,
  input  wire logic [HALF_W-1:0]    id_high,
  input  wire logic [HALF_W-1:0]    id_low,
  input  wire logic [HALF_W-1:0]    phone_high,
  input  wire logic [HALF_W-1:0]    phone_low,
  input  wire logic [HALF_W-1:0]    msgr_high,
  input  wire logic [HALF_W-1:0]    msgr_low,
  // output channel
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [2:0]                status,
  output logic [SLOT_W-1:0]         slot,
  output logic [ECOUNT_W-1:0]       entry_count,
  output logic [HALF_W-1:0]         out_name_high,
  output logic [HALF_W-1:0]         out_name_low,
  output logic [HALF_W-1:0]         out_id_high,
  output logic [HALF_W-1:0]         out_id_low,
  output logic [HALF_W-1:0]         out_phone_high,
  output logic [HALF_W-1:0]         out_phone_low,
  output logic [HALF_W-1:0]         out_msgr_high,
  output logic [HALF_W-1:0]         out_msgr_low
);

  ctl_cmd_t ctl;
  dp_stat_t dp_stat;

  // sequencer
  mkrt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (dp_stat),
    .cmd      (ctl)
  );

  // memories, marks, compare and result register
  mkrt_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (ctl),
    .stat           (dp_stat),
    .command        (command),
    .key_field      (key_field),
    .key_high       (key_high),
    .key_low        (key_low),
    .name_high      (name_high),
    .name_low       (name_low),
    .id_high        (id_high),
    .id_low         (id_low),
    .phone_high     (phone_high),
    .phone_low      (phone_low),
    .msgr_high      (msgr_high),
    .msgr_low       (msgr_low),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .status         (status),
    .slot           (slot),
    .entry_count    (entry_count),
    .out_name_high  (out_name_high),
    .out_name_low   (out_name_low),
    .out_id_high    (out_id_high),
    .out_id_low     (out_id_low),
    .out_phone_high (out_phone_high),
    .out_phone_low  (out_phone_low),
    .out_msgr_high  (out_msgr_high),
    .out_msgr_low   (out_msgr_low)
  );

  // one command in flight: a taken beat closes the input side
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input beat taken while a command is in flight");

  // a result is never written over one that is still stalled
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    ctl.load_out |-> !(out_valid && out_stall))
    else $error("result register loaded while its beat is stalled");

  // a reported count never passes the table size
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (entry_count <= ECOUNT_W'(ENTRIES)))
    else $error("entry count above table size");

  // a miss or a full table carries no slot and no record
  a_miss_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status == RES_NOT_FOUND || status == RES_FULL)) |->
      (slot == '0 && out_name_high == '0 && out_msgr_low == '0))
    else $error("miss result carries slot or record data");

endmodule

`default_nettype wire
